/* design/nla_pkg.sv */
// Shared types and constants for the length-prefix to start-code converter.
// No dependencies.
`timescale 1ns / 1ps

package nla_pkg;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int BLOCK_LEN_W = 24;
    localparam int LEN_W       = 32;
    localparam int SUM_W       = LEN_W + 1;
    localparam int CFG_W       = 3;

    // Configuration register
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam logic REG_PREFIX_BYTES = 1'b0;   // register index (paddr[2])
    localparam logic [CFG_W-1:0] PREFIX_BYTES_RESET = 3'd4;
    localparam logic [CFG_W-1:0] PREFIX_MIN = 3'd1;
    localparam logic [CFG_W-1:0] PREFIX_MAX = 3'd4;

    // Start code 00 00 00 01
    localparam logic [1:0] START_LAST_IDX = 2'd3;
    localparam logic [BYTE_W-1:0] START_ONE = 8'h01;

    typedef enum logic [1:0] {
        RUN_START,      // four start-code bytes
        RUN_DATA,       // one payload byte
        RUN_MARK        // end-of-block marker, no data
    } run_kind_t;

    // One group of results caused by a single input request
    typedef struct packed {
        run_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic              done;
    } run_desc_t;

endpackage

/* design/nla_stream_if.sv */
// Valid/ready channel interfaces for input bytes and converted results.
// Depends on nla_pkg.
`timescale 1ns / 1ps

interface nla_in_if
    import nla_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [BYTE_W-1:0]      in_byte;
    logic [BLOCK_LEN_W-1:0] block_len;

    modport source (output valid, output in_byte, output block_len, input ready);
    modport sink   (input valid, input in_byte, input block_len, output ready);
endinterface

interface nla_out_if
    import nla_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              block_done;
    logic              run_last;

    modport source (output valid, output out_byte, output byte_valid,
                    output block_done, output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input block_done, input run_last, output ready);
endinterface

/* design/nal_length_to_annexb_converter.sv */
// Length-prefixed (AVCC/HVCC) to Annex B NAL converter, one byte per request.
// The first result of a request is registered in the parser's run descriptor and then in
// the emitter's current run before it appears on the result port.
// Throughput: one input byte per cycle while the result port is ready; a completed prefix
// yields 4 results, limited by the single result port, so input stalls while they play out.
// Reset (rst_n, async low) clears block tracking; prefix_bytes returns to 4.
`timescale 1ns / 1ps

module nal_length_to_annexb_converter
    import nla_pkg::*;
#(
    parameter int BLOCK_LEN_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    nla_in_if.sink                item,
    nla_out_if.source             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration register: prefix size. Decoded on paddr[2] only, so any
    // address in the first word selects it.
    logic [CFG_W-1:0] prefix_bytes_reg, prefix_bytes_next;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PREFIX_BYTES);

    always_comb
    begin
        prefix_bytes_next = cfg_write ? pwdata[CFG_W-1:0] : prefix_bytes_reg;
        prdata = (paddr[2] == REG_PREFIX_BYTES) ?
                 {{(APB_DATA_W-CFG_W){1'b0}}, prefix_bytes_reg} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prefix_bytes_reg <= PREFIX_BYTES_RESET;
        else
            prefix_bytes_reg <= prefix_bytes_next;
    end

    // Parser -> emitter run descriptor handoff
    logic      run_valid;
    run_desc_t run;
    logic      run_take;

    nla_parser #(
        .BLOCK_LEN_BITS (BLOCK_LEN_BITS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .prefix_bytes (prefix_bytes_reg),
        .run_valid    (run_valid),
        .run          (run),
        .run_take     (run_take)
    );

    nla_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_valid (run_valid),
        .run       (run),
        .run_take  (run_take),
        .result    (result)
    );

    // Block end always closes a run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.block_done |-> result.run_last)
        else $error("block_done without run_last");

    // A marker result only appears as the block's final result
    a_marker_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.byte_valid |-> result.block_done && result.run_last)
        else $error("marker result not at block end");

    // Only start codes span several results; leading bytes are zero data
    a_start_code_body: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.run_last |-> result.byte_valid && result.out_byte == '0)
        else $error("bad start-code byte");

endmodule

/* design/nla_parser.sv */
// Block parser: tracks position, prefix assembly and payload count per byte,
// and registers at most one run descriptor per request. Depends on nla_pkg.
`timescale 1ns / 1ps

module nla_parser
    import nla_pkg::*;
#(
    parameter int BLOCK_LEN_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    nla_in_if.sink           item,
    input  logic [CFG_W-1:0] prefix_bytes,
    output logic             run_valid,
    output run_desc_t        run,
    input  logic             run_take
);

    localparam int PosW = (BLOCK_LEN_BITS < BLOCK_LEN_W) ? BLOCK_LEN_BITS : BLOCK_LEN_W;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic [PosW-1:0]   left_reg, left_next;
    logic              run_valid_reg, run_valid_next;
    run_desc_t         run_reg, run_next;

    logic              accept;
    logic [PosW:0]     pos_inc;
    logic [PosW-1:0]   blen;
    logic              last;
    logic [CFG_W-1:0]  ls;
    logic [LEN_W-1:0]  acc_shift;
    logic [SUM_W-1:0]  end_sum;
    logic              fits;
    logic              emit;
    run_kind_t         kind;

    assign item.ready = !run_valid_reg || run_take;
    assign accept     = item.valid && item.ready;
    assign run_valid  = run_valid_reg;
    assign run        = run_reg;

    always_comb
    begin
        blen      = item.block_len[PosW-1:0];
        pos_inc   = {1'b0, pos_reg} + {{PosW{1'b0}}, 1'b1};
        last      = pos_inc >= {1'b0, blen};
        if (prefix_bytes < PREFIX_MIN)
            ls = PREFIX_MIN;
        else if (prefix_bytes > PREFIX_MAX)
            ls = PREFIX_MAX;
        else
            ls = prefix_bytes;
        acc_shift = {acc_reg[LEN_W-BYTE_W-1:0], item.in_byte};
        end_sum   = SUM_W'(pos_inc) + {1'b0, acc_shift};
        fits      = (acc_shift != '0) && (end_sum <= SUM_W'(blen));

        phase_next     = phase_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        left_next      = left_reg;
        run_valid_next = run_valid_reg && !run_take;
        run_next       = run_reg;
        emit           = 1'b0;
        kind           = RUN_MARK;

        if (accept)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if (({1'b0, cnt_reg} + 3'd1) >= ls)
                    begin
                        cnt_next = '0;
                        acc_next = '0;
                        if (fits)
                        begin
                            emit       = 1'b1;
                            kind       = RUN_START;
                            left_next  = acc_shift[PosW-1:0];
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            phase_next = PH_DISCARD;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                        acc_next = acc_shift;
                    end
                end
                PH_PAYLOAD:
                begin
                    emit      = 1'b1;
                    kind      = RUN_DATA;
                    left_next = left_reg - {{(PosW-1){1'b0}}, 1'b1};
                    if (left_reg == {{(PosW-1){1'b0}}, 1'b1})
                        phase_next = PH_PREFIX;
                end
                default:
                begin
                    // discard the rest of the block
                end
            endcase

            if (last)
            begin
                phase_next = PH_PREFIX;
                pos_next   = '0;
                cnt_next   = '0;
                acc_next   = '0;
                left_next  = '0;
            end
            else
            begin
                pos_next = pos_inc[PosW-1:0];
            end

            run_valid_next = emit || last;
            run_next.kind  = kind;
            run_next.data  = item.in_byte;
            run_next.done  = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREFIX;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            left_reg      <= '0;
            run_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            left_reg      <= left_next;
            run_valid_reg <= run_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

endmodule

/* design/nla_emitter.sv */
// Result sequencer: plays out a run descriptor one result per cycle while result.ready is high.
// Depends on nla_pkg.
`timescale 1ns / 1ps

module nla_emitter
    import nla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       run_valid,
    input  run_desc_t  run,
    output logic       run_take,
    nla_out_if.source  result
);

    logic       busy_reg, busy_next;
    run_desc_t  cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       final_idx;

    always_comb
    begin
        final_idx = (cur_reg.kind == RUN_START) ? (idx_reg == START_LAST_IDX) : 1'b1;
        run_take  = !busy_reg || (result.ready && final_idx);

        result.valid      = busy_reg;
        result.byte_valid = (cur_reg.kind != RUN_MARK);
        result.run_last   = final_idx;
        result.block_done = cur_reg.done && final_idx;
        case (cur_reg.kind)
            RUN_START: result.out_byte = final_idx ? START_ONE : '0;
            RUN_DATA:  result.out_byte = cur_reg.data;
            default:   result.out_byte = '0;
        endcase

        busy_next = busy_reg;
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        if (run_take)
        begin
            busy_next = run_valid;
            cur_next  = run;
            idx_next  = '0;
        end
        else if (result.ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule
